[hw/rtl/dca_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dca_pkg
// Types and constants shared by the distance constraint accumulator modules.
// ----------------------------------------------------------------------------
package dca_pkg;

    localparam int MaxParticlesDef = 256;
    localparam int FUNC_W = 2;
    localparam int IDX_W  = 8;
    localparam int POS_W  = 32;
    localparam int REST_W = 31;
    localparam int ACC_W  = 48;
    localparam int WGT_W  = 16;
    localparam int OFF_W  = 34;
    localparam int IN_W   = 144;
    localparam int OUT_W  = 160;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD  = 2'd0,
        FN_APPLY = 2'd1,
        FN_READ  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef struct packed {
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } t_vec3;

    typedef struct packed {
        logic  pin;
        t_vec3 pos;
    } t_particle;

    typedef struct packed {
        logic        [WGT_W-1:0] w;
        logic signed [ACC_W-1:0] z;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] x;
    } t_acc;

    typedef struct packed {
        logic signed [OFF_W-1:0] z;
        logic signed [OFF_W-1:0] y;
        logic signed [OFF_W-1:0] x;
    } t_off3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_POS_A,
        ST_POS_B,
        ST_START,
        ST_SOLVE,
        ST_ACC_RD_A,
        ST_ACC_WR_A,
        ST_ACC_RD_B,
        ST_ACC_WR_B,
        ST_OUT_RD,
        ST_OUT
    } t_top_state;

    typedef enum logic [3:0] {
        SV_IDLE,
        SV_SHIFT,
        SV_SQ,
        SV_SQRT,
        SV_MUL,
        SV_DIVI,
        SV_DIV,
        SV_OFF,
        SV_DONE
    } t_slv_state;

endpackage
`default_nettype wire

[hw/rtl/dca_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dca_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module dca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/dca_solver.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dca_solver
// Iterative datapath that turns two positions and a rest length into the
// offsets added to each particle: serial square root and serial division.
// ----------------------------------------------------------------------------
module dca_solver import dca_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_vec3             i_pos_a,
    input  wire t_vec3             i_pos_b,
    input  wire logic [REST_W-1:0] i_rest,
    output logic                   o_done,
    output t_off3                  o_off_a,
    output t_off3                  o_off_b
);

    t_slv_state r_state;
    t_slv_state n_state;

    logic signed [POS_W:0]   r_d [3];
    logic signed [POS_W-1:0] r_c [3];
    logic signed [POS_W-1:0] r_h [3];
    logic        [29:0]      r_m [3];
    logic        [2:0]       r_neg;
    logic        [REST_W-1:0] r_rest;
    logic        [1:0]       r_k;
    logic        [1:0]       r_axis;
    logic        [4:0]       r_cnt;
    logic        [59:0]      r_prod;
    logic        [61:0]      r_sum;
    logic        [61:0]      r_res;
    logic        [61:0]      r_bit;
    logic        [60:0]      r_mprod;
    logic        [32:0]      r_rem;
    logic        [30:0]      r_num;
    logic        [30:0]      r_q;

    logic signed [POS_W-1:0] pa [3];
    logic signed [POS_W-1:0] pb [3];
    logic        [POS_W:0]   mag [3];
    logic        [POS_W:0]   big;
    logic        [1:0]       sh;
    logic        [61:0]      sq_t;
    logic        [30:0]      len;
    logic        [32:0]      dvs;
    logic        [32:0]      rem2;
    logic                    qbit;
    logic        [30:0]      n_q;
    logic        [POS_W-1:0] qx;

    always_comb begin
        pa[0] = i_pos_a.x;
        pa[1] = i_pos_a.y;
        pa[2] = i_pos_a.z;
        pb[0] = i_pos_b.x;
        pb[1] = i_pos_b.y;
        pb[2] = i_pos_b.z;
        for (int k = 0; k < 3; k++) begin
            mag[k] = r_d[k][POS_W] ? 33'(-r_d[k]) : 33'(r_d[k]);
        end
        big = mag[0];
        if (mag[1] > big) begin
            big = mag[1];
        end
        if (mag[2] > big) begin
            big = mag[2];
        end
        if (big[32]) begin
            sh = 2'd3;
        end else if (big[31]) begin
            sh = 2'd2;
        end else if (big[30]) begin
            sh = 2'd1;
        end else begin
            sh = 2'd0;
        end
        sq_t = r_res + r_bit;
        len  = r_res[30:0];
        dvs  = {1'b0, len, 1'b0};
        rem2 = {r_rem[31:0], r_num[30]};
        qbit = (rem2 >= dvs);
        n_q  = {r_q[29:0], qbit};
        qx   = (len == 31'd0) ? '0 : {1'b0, n_q};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            SV_IDLE: begin
                if (i_start) begin
                    n_state = SV_SHIFT;
                end
            end
            SV_SHIFT: n_state = SV_SQ;
            SV_SQ: begin
                if (r_k == 2'd3) begin
                    n_state = SV_SQRT;
                end
            end
            SV_SQRT: begin
                if (r_cnt == 5'd30) begin
                    n_state = SV_MUL;
                end
            end
            SV_MUL:  n_state = SV_DIVI;
            SV_DIVI: n_state = SV_DIV;
            SV_DIV: begin
                if (r_cnt == 5'd30) begin
                    n_state = (r_axis == 2'd2) ? SV_OFF : SV_MUL;
                end
            end
            SV_OFF:  n_state = SV_DONE;
            SV_DONE: n_state = SV_IDLE;
            default: n_state = SV_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == SV_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SV_IDLE: begin
                if (i_start) begin
                    for (int k = 0; k < 3; k++) begin
                        r_d[k] <= 33'(pb[k]) - 33'(pa[k]);
                        r_c[k] <= 32'((33'(pa[k]) + 33'(pb[k])) >>> 1);
                    end
                    r_rest <= i_rest;
                end
            end
            SV_SHIFT: begin
                for (int k = 0; k < 3; k++) begin
                    r_m[k]   <= 30'(mag[k] >> sh);
                    r_neg[k] <= r_d[k][POS_W];
                end
                r_k   <= 2'd0;
                r_sum <= '0;
            end
            SV_SQ: begin
                if (r_k != 2'd3) begin
                    r_prod <= r_m[r_k] * r_m[r_k];
                end
                if (r_k != 2'd0) begin
                    r_sum <= r_sum + 62'(r_prod);
                end
                r_k   <= r_k + 2'd1;
                r_cnt <= '0;
                r_res <= '0;
                r_bit <= 62'd1 << 60;
            end
            SV_SQRT: begin
                if (r_sum >= sq_t) begin
                    r_sum <= r_sum - sq_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_cnt  <= r_cnt + 5'd1;
                r_axis <= 2'd0;
            end
            SV_MUL: begin
                r_mprod <= r_m[r_axis] * r_rest;
            end
            SV_DIVI: begin
                r_rem <= {3'b000, r_mprod[60:31]};
                r_num <= r_mprod[30:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            SV_DIV: begin
                r_rem <= qbit ? (rem2 - dvs) : rem2;
                r_num <= {r_num[29:0], 1'b0};
                r_q   <= n_q;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_h[r_axis] <= r_neg[r_axis] ? -qx : qx;
                    r_axis      <= r_axis + 2'd1;
                end
            end
            SV_OFF: begin
                o_off_a.x <= 34'(r_c[0]) - 34'(r_h[0]);
                o_off_a.y <= 34'(r_c[1]) - 34'(r_h[1]);
                o_off_a.z <= 34'(r_c[2]) - 34'(r_h[2]);
                o_off_b.x <= 34'(r_c[0]) + 34'(r_h[0]);
                o_off_b.y <= 34'(r_c[1]) + 34'(r_h[1]);
                o_off_b.z <= 34'(r_c[2]) + 34'(r_h[2]);
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/distance_constraint_accumulator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// distance_constraint_accumulator
// Particle table with load, distance constraint apply and accumulator read.
// ----------------------------------------------------------------------------
// One item is worked on at a time and every item returns one result item with
// the accumulator and weight of particle index_a. An apply runs the solver: a
// square root that resolves one result bit per cycle and three divisions that
// resolve one quotient bit per cycle. Particle data and accumulators sit in
// two RAMs with registered reads, each touched through one read and one write
// port. A new item is taken while the previous result still waits on the
// output register.
// ----------------------------------------------------------------------------
module distance_constraint_accumulator import dca_pkg::*; #(
    parameter int MAX_PARTICLES = MaxParticlesDef
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // index_a[7:0], index_b[15:8], pos_x[47:16], pos_y[79:48],
    // pos_z[111:80], pin[112], rest_length[143:113]
    input  wire logic [IN_W-1:0]   i_s_axis_tdata,
    // func[1:0]
    input  wire logic [FUNC_W-1:0] i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // sum_x[47:0], sum_y[95:48], sum_z[143:96], hits[159:144]
    output logic [OUT_W-1:0]       o_m_axis_tdata
);

    localparam int AW = $clog2(MAX_PARTICLES);

    t_top_state r_state;
    t_top_state n_state;

    t_func            r_func;
    logic [AW-1:0]    r_a;
    logic [AW-1:0]    r_b;
    logic [REST_W-1:0] r_rest;
    t_particle        r_ld;
    t_particle        r_pos_a;
    t_particle        r_pos_b;
    logic             r_m_valid;
    t_acc             r_out;

    logic      s_accept;
    logic      out_free;
    logic      out_load;
    logic      slv_start;
    logic      slv_done;
    t_off3     off_a;
    t_off3     off_b;
    logic      pos_we;
    logic [AW-1:0] pos_raddr;
    t_particle pos_rdata;
    logic      acc_we;
    logic [AW-1:0] acc_waddr;
    logic [AW-1:0] acc_raddr;
    t_acc      acc_wdata;
    t_acc      acc_rdata;

    function automatic logic [AW-1:0] wrap_idx(logic [IDX_W-1:0] v);
        logic [20:0] r;
        logic [20:0] t;
        r = 21'(v);
        for (int i = IDX_W - 1; i >= 0; i--) begin
            t = 21'(MAX_PARTICLES) << i;
            if (r >= t) begin
                r = r - t;
            end
        end
        return r[AW-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1]) begin
            r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    function automatic t_acc acc_add(t_acc cur, t_off3 off);
        t_acc r;
        r.x = sat_acc(49'(cur.x) + 49'(off.x));
        r.y = sat_acc(49'(cur.y) + 49'(off.y));
        r.z = sat_acc(49'(cur.z) + 49'(off.z));
        r.w = (cur.w == '1) ? cur.w : cur.w + 16'd1;
        return r;
    endfunction

    assign s_accept = i_s_axis_tvalid & o_s_axis_tready;
    assign out_free = !r_m_valid | i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    case (t_func'(i_s_axis_tuser))
                        FN_LOAD:  n_state = ST_LOAD;
                        FN_APPLY: n_state = ST_POS_A;
                        default:  n_state = ST_OUT_RD;
                    endcase
                end
            end
            ST_LOAD:     n_state = ST_OUT_RD;
            ST_POS_A:    n_state = ST_POS_B;
            ST_POS_B:    n_state = ST_START;
            ST_START:    n_state = ST_SOLVE;
            ST_SOLVE: begin
                if (slv_done) begin
                    n_state = ST_ACC_RD_A;
                end
            end
            ST_ACC_RD_A: n_state = ST_ACC_WR_A;
            ST_ACC_WR_A: n_state = ST_ACC_RD_B;
            ST_ACC_RD_B: n_state = ST_ACC_WR_B;
            ST_ACC_WR_B: n_state = ST_OUT_RD;
            ST_OUT_RD:   n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        pos_we          = 1'b0;
        pos_raddr       = r_a;
        acc_we          = 1'b0;
        acc_waddr       = r_a;
        acc_raddr       = r_a;
        acc_wdata       = '0;
        slv_start       = 1'b0;
        out_load        = 1'b0;
        case (r_state)
            ST_IDLE:  o_s_axis_tready = 1'b1;
            ST_LOAD: begin
                pos_we = 1'b1;
                acc_we = 1'b1;
            end
            ST_POS_B: pos_raddr = r_b;
            ST_START: slv_start = 1'b1;
            ST_ACC_WR_A: begin
                acc_we    = !r_pos_a.pin;
                acc_wdata = acc_add(acc_rdata, off_a);
            end
            ST_ACC_RD_B: acc_raddr = r_b;
            ST_ACC_WR_B: begin
                acc_we    = !r_pos_b.pin;
                acc_waddr = r_b;
                acc_wdata = acc_add(acc_rdata, off_b);
            end
            ST_OUT:   out_load = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_func    <= t_func'(i_s_axis_tuser);
            r_a       <= wrap_idx(i_s_axis_tdata[7:0]);
            r_b       <= wrap_idx(i_s_axis_tdata[15:8]);
            r_ld.pos.x <= i_s_axis_tdata[47:16];
            r_ld.pos.y <= i_s_axis_tdata[79:48];
            r_ld.pos.z <= i_s_axis_tdata[111:80];
            r_ld.pin  <= i_s_axis_tdata[112];
            r_rest    <= i_s_axis_tdata[143:113];
        end
        if (r_state == ST_POS_B) begin
            r_pos_a <= pos_rdata;
        end
        if (r_state == ST_START) begin
            r_pos_b <= pos_rdata;
        end
        if (out_load) begin
            r_out <= acc_rdata;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_out;

    dca_ram #(
        .WIDTH($bits(t_particle)),
        .DEPTH(MAX_PARTICLES)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (r_a),
        .i_wdata (r_ld),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    dca_ram #(
        .WIDTH($bits(t_acc)),
        .DEPTH(MAX_PARTICLES)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    dca_solver u_solver (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (slv_start && (r_func == FN_APPLY)),
        .i_pos_a (r_pos_a.pos),
        .i_pos_b (pos_rdata.pos),
        .i_rest  (r_rest),
        .o_done  (slv_done),
        .o_off_a (off_a),
        .o_off_b (off_b)
    );

endmodule
`default_nettype wire
